/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL modules.
// Every property is sampled on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, cond, msg)
`define ASSERT_IMPLY(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* rtl/sncs_pkg.sv */
`default_nettype none

package sncs_pkg;

  // Input item kinds.
  localparam logic [2:0] CMD_READ   = 3'd0;
  localparam logic [2:0] CMD_PROG   = 3'd1;
  localparam logic [2:0] CMD_SERASE = 3'd2;
  localparam logic [2:0] CMD_CERASE = 3'd3;
  localparam logic [2:0] CMD_DATA   = 3'd4;
  localparam logic [2:0] CMD_RXBYTE = 3'd5;

  // Stored operation of a command in flight.
  localparam logic [1:0] OPER_READ   = 2'd0;
  localparam logic [1:0] OPER_PROG   = 2'd1;
  localparam logic [1:0] OPER_SERASE = 2'd2;
  localparam logic [1:0] OPER_CERASE = 2'd3;

  // Result actions.
  localparam logic [2:0] ACT_SEL_LOW  = 3'd0;
  localparam logic [2:0] ACT_SEND     = 3'd1;
  localparam logic [2:0] ACT_XFER     = 3'd2;
  localparam logic [2:0] ACT_SEL_HIGH = 3'd3;
  localparam logic [2:0] ACT_READ     = 3'd4;
  localparam logic [2:0] ACT_DONE     = 3'd5;
  localparam logic [2:0] ACT_REJECT   = 3'd6;

  // Flash opcodes and fixed bytes.
  localparam logic [7:0] OPC_WREN  = 8'h06;
  localparam logic [7:0] OPC_RDSR  = 8'h05;
  localparam logic [7:0] OPC_READ  = 8'h03;
  localparam logic [7:0] OPC_PP    = 8'h02;
  localparam logic [7:0] OPC_SE    = 8'h20;
  localparam logic [7:0] OPC_CE    = 8'hC7;
  localparam logic [7:0] DUMMY     = 8'hFF;
  localparam logic [7:0] BUSY_MASK = 8'h01;

  // Every job is a subset of one fixed ordered list of slots; the back end
  // walks the enabled slots from the lowest up, one result per cycle while the output is not stalled.
  localparam int NUM_SLOTS = 15;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);

  typedef logic [NUM_SLOTS-1:0] slot_mask_t;
  typedef logic [SLOT_W-1:0]    slot_idx_t;

  localparam slot_idx_t SLOT_RD_BYTE   = 4'd0;   // read byte (data)
  localparam slot_idx_t SLOT_PROG_BYTE = 4'd1;   // send data
  localparam slot_idx_t SLOT_POLL_END  = 4'd2;   // select high
  localparam slot_idx_t SLOT_CMD_SEL   = 4'd3;   // select low
  localparam slot_idx_t SLOT_CMD_OPC   = 4'd4;   // send opcode
  localparam slot_idx_t SLOT_ADDR_HI   = 4'd5;
  localparam slot_idx_t SLOT_ADDR_MID  = 4'd6;
  localparam slot_idx_t SLOT_ADDR_LO   = 4'd7;
  localparam slot_idx_t SLOT_CMD_END   = 4'd8;   // select high
  localparam slot_idx_t SLOT_POLL_SEL  = 4'd9;   // select low
  localparam slot_idx_t SLOT_POLL_OPC  = 4'd10;  // send 0x05
  localparam slot_idx_t SLOT_POLL_XFER = 4'd11;  // send 0xFF and capture
  localparam slot_idx_t SLOT_FIN_END   = 4'd12;  // select high
  localparam slot_idx_t SLOT_FIN_DONE  = 4'd13;  // done
  localparam slot_idx_t SLOT_REJECT    = 4'd14;

  localparam slot_mask_t M_ONE = slot_mask_t'(1);

  localparam slot_mask_t M_RD_BYTE   = M_ONE << SLOT_RD_BYTE;
  localparam slot_mask_t M_PROG_BYTE = M_ONE << SLOT_PROG_BYTE;
  localparam slot_mask_t M_POLL_END  = M_ONE << SLOT_POLL_END;
  localparam slot_mask_t M_CMD_HEAD  = (M_ONE << SLOT_CMD_SEL) | (M_ONE << SLOT_CMD_OPC);
  localparam slot_mask_t M_ADDR      = (M_ONE << SLOT_ADDR_HI) | (M_ONE << SLOT_ADDR_MID) |
                                       (M_ONE << SLOT_ADDR_LO);
  localparam slot_mask_t M_CMD_END   = M_ONE << SLOT_CMD_END;
  localparam slot_mask_t M_POLL_HEAD = (M_ONE << SLOT_POLL_SEL) | (M_ONE << SLOT_POLL_OPC);
  localparam slot_mask_t M_XFER      = M_ONE << SLOT_POLL_XFER;
  localparam slot_mask_t M_CLOSE     = (M_ONE << SLOT_FIN_END) | (M_ONE << SLOT_FIN_DONE);
  localparam slot_mask_t M_REJECT    = M_ONE << SLOT_REJECT;
  localparam slot_mask_t M_FINISH    = M_CMD_END | M_POLL_HEAD | M_XFER;

  // Job handed from the front end to the back end.
  typedef struct packed {
    slot_mask_t  mask;
    logic [7:0]  opcode;
    logic [23:0] addr;
    logic [7:0]  data;
  } job_t;

  // Queue status seen by the input handshake and the back end.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

endpackage

`default_nettype wire

/* rtl/spi_nor_flash_command_sequencer_unit.sv */
// An item goes via the job queue and the back end's current-job register into the
// output register. Throughput: an item with N results (1 to 10) yields one result per
// cycle while out_tready is high; the back end's single output register sets it.
// A two-entry job queue lets the next items be accepted while results drain.
// Reset (rst_n low, synchronous) returns to idle with the queue and output empty.
`default_nettype none

module spi_nor_flash_command_sequencer_unit
  import sncs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // addr[23:0], count[39:24], data[47:40]
  input  wire logic [2:0]  in_tuser,   // cmd[2:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // byte_value[7:0]
  output logic [2:0]       out_tuser,  // action[2:0]
  output logic             out_tlast
);

  logic      accept;
  logic      pop;
  job_t      new_job;
  job_t      head_job;
  q_status_t q_status;

  assign in_tready = !q_status.full;
  assign accept    = in_tvalid && in_tready;

  sncs_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .accept(accept),
    .cmd   (in_tuser),
    .addr  (in_tdata[23:0]),
    .count (in_tdata[39:24]),
    .data  (in_tdata[47:40]),
    .job   (new_job)
  );

  sncs_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (accept),
    .push_job(new_job),
    .pop     (pop),
    .head_job(head_job),
    .status  (q_status)
  );

  sncs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_job  (head_job),
    .q_status  (q_status),
    .pop       (pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule

`default_nettype wire

/* rtl/sncs_front.sv */
`default_nettype none

`include "assert_macros.svh"

module sncs_front
  import sncs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        accept,
  input  wire logic [2:0]  cmd,
  input  wire logic [23:0] addr,
  input  wire logic [15:0] count,
  input  wire logic [7:0]  data,
  output job_t             job
);

  typedef enum logic [4:0] {
    PH_IDLE      = 5'b00001,
    PH_POLL_PRE  = 5'b00010,
    PH_PROG_DATA = 5'b00100,
    PH_POLL_POST = 5'b01000,
    PH_READ_DATA = 5'b10000
  } phase_t;

  phase_t      phase_r,      phase_nxt;
  logic [1:0]  operation_r,  operation_nxt;
  logic [23:0] addr_r,       addr_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic [15:0] bytes_dec;
  logic        busy;

  assign bytes_dec = bytes_left_r - 16'd1;
  assign busy      = (data & BUSY_MASK) != 8'h00;

  always_comb begin
    phase_nxt      = phase_r;
    operation_nxt  = operation_r;
    addr_nxt       = addr_r;
    bytes_left_nxt = bytes_left_r;
    job.mask       = M_REJECT;
    job.opcode     = OPC_READ;
    job.addr       = addr_r;
    job.data       = data;

    unique case (phase_r)
      PH_POLL_PRE: begin
        if (cmd == CMD_RXBYTE) begin
          if (busy) begin
            job.mask = M_XFER;
          end else begin
            job.mask = M_POLL_END | M_CMD_HEAD;
            unique case (operation_r)
              OPER_PROG: begin
                job.opcode = OPC_PP;
                job.mask   = job.mask | M_ADDR;
              end
              OPER_SERASE: begin
                job.opcode = OPC_SE;
                job.mask   = job.mask | M_ADDR;
              end
              default: job.opcode = OPC_CE;
            endcase
            if (operation_r == OPER_PROG && bytes_left_r != 16'd0) begin
              phase_nxt = PH_PROG_DATA;
            end else begin
              job.mask  = job.mask | M_FINISH;
              phase_nxt = PH_POLL_POST;
            end
          end
        end
      end
      PH_PROG_DATA: begin
        if (cmd == CMD_DATA) begin
          job.mask       = M_PROG_BYTE;
          bytes_left_nxt = bytes_dec;
          if (bytes_dec == 16'd0) begin
            job.mask  = M_PROG_BYTE | M_FINISH;
            phase_nxt = PH_POLL_POST;
          end
        end
      end
      PH_POLL_POST: begin
        if (cmd == CMD_RXBYTE) begin
          if (busy) begin
            job.mask = M_XFER;
          end else begin
            job.mask  = M_CLOSE;
            phase_nxt = PH_IDLE;
          end
        end
      end
      PH_READ_DATA: begin
        if (cmd == CMD_RXBYTE) begin
          bytes_left_nxt = bytes_dec;
          if (bytes_dec != 16'd0) begin
            job.mask = M_RD_BYTE | M_XFER;
          end else begin
            job.mask  = M_RD_BYTE | M_CLOSE;
            phase_nxt = PH_IDLE;
          end
        end
      end
      default: begin
        job.addr = addr;
        unique case (cmd) inside
          CMD_READ: begin
            operation_nxt  = OPER_READ;
            addr_nxt       = addr;
            bytes_left_nxt = count;
            if (count != 16'd0) begin
              job.mask  = M_CMD_HEAD | M_ADDR | M_XFER;
              phase_nxt = PH_READ_DATA;
            end else begin
              job.mask  = M_CMD_HEAD | M_ADDR | M_CLOSE;
              phase_nxt = PH_IDLE;
            end
          end
          CMD_PROG, CMD_SERASE, CMD_CERASE: begin
            operation_nxt  = cmd[1:0];
            addr_nxt       = addr;
            bytes_left_nxt = (cmd == CMD_PROG) ? count : 16'd0;
            job.opcode     = OPC_WREN;
            job.mask       = M_CMD_HEAD | M_FINISH;
            phase_nxt      = PH_POLL_PRE;
          end
          default: job.mask = M_REJECT;
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      operation_r  <= OPER_READ;
      addr_r       <= 24'd0;
      bytes_left_r <= 16'd0;
    end else if (accept) begin
      phase_r      <= phase_nxt;
      operation_r  <= operation_nxt;
      addr_r       <= addr_nxt;
      bytes_left_r <= bytes_left_nxt;
    end
  end

  // Program data is only awaited while bytes remain to be sent.
  `ASSERT_IMPLY(a_prog_left, phase_r == PH_PROG_DATA, bytes_left_r != 16'd0, "program phase with no bytes left")
  // Data may only be expected for a page program.
  `ASSERT_IMPLY(a_prog_oper, phase_r == PH_PROG_DATA, operation_r == OPER_PROG, "program phase for non-program operation")
  `ASSERT_ALWAYS(a_phase_onehot, $onehot(phase_r), "phase register not one-hot")

endmodule

`default_nettype wire

/* rtl/sncs_queue.sv */
`default_nettype none

`include "assert_macros.svh"

module sncs_queue
  import sncs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output job_t      head_job,
  output q_status_t status
);

  job_t                mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r;
  logic [QUEUE_AW-1:0] rd_ptr_r;
  logic [QUEUE_CW-1:0] count_r;

  function automatic logic [QUEUE_AW-1:0] ptr_inc(input logic [QUEUE_AW-1:0] p);
    ptr_inc = (p == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign status.full  = count_r == QUEUE_CW'(QUEUE_DEPTH);
  assign status.empty = count_r == '0;
  assign head_job     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  `ASSERT_ALWAYS(a_q_bound, count_r <= QUEUE_CW'(QUEUE_DEPTH), "queue count beyond depth")
  `ASSERT_IMPLY(a_q_under, pop, !status.empty, "pop from empty queue")
  `ASSERT_IMPLY(a_q_over, push, !status.full || pop, "push into full queue")

endmodule

`default_nettype wire

/* rtl/sncs_back.sv */
`default_nettype none

`include "assert_macros.svh"

module sncs_back
  import sncs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire job_t       head_job,
  input  wire q_status_t  q_status,
  output logic            pop,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,
  output logic [2:0]      out_tuser,
  output logic            out_tlast
);

  job_t       cur_r;
  slot_mask_t rest;
  slot_idx_t  slot;
  logic       have_job;
  logic       out_load;
  logic       emit;
  logic       is_last;
  logic       out_valid_r;
  logic [2:0] act;
  logic [7:0] byte_val;

  assign have_job = cur_r.mask != '0;
  assign out_load = !out_valid_r || out_tready;
  assign emit     = out_load && have_job;
  assign rest     = cur_r.mask & (cur_r.mask - M_ONE);
  assign is_last  = rest == '0;
  assign pop      = !q_status.empty && (!have_job || (emit && is_last));

  // Lowest enabled slot goes out first.
  always_comb begin
    slot = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (cur_r.mask[i]) begin
        slot = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    act      = ACT_REJECT;
    byte_val = 8'h00;
    unique case (slot) inside
      SLOT_RD_BYTE: begin
        act      = ACT_READ;
        byte_val = cur_r.data;
      end
      SLOT_PROG_BYTE: begin
        act      = ACT_SEND;
        byte_val = cur_r.data;
      end
      SLOT_POLL_END, SLOT_CMD_END, SLOT_FIN_END: act = ACT_SEL_HIGH;
      SLOT_CMD_SEL, SLOT_POLL_SEL:               act = ACT_SEL_LOW;
      SLOT_CMD_OPC: begin
        act      = ACT_SEND;
        byte_val = cur_r.opcode;
      end
      SLOT_ADDR_HI: begin
        act      = ACT_SEND;
        byte_val = cur_r.addr[23:16];
      end
      SLOT_ADDR_MID: begin
        act      = ACT_SEND;
        byte_val = cur_r.addr[15:8];
      end
      SLOT_ADDR_LO: begin
        act      = ACT_SEND;
        byte_val = cur_r.addr[7:0];
      end
      SLOT_POLL_OPC: begin
        act      = ACT_SEND;
        byte_val = OPC_RDSR;
      end
      SLOT_POLL_XFER: begin
        act      = ACT_XFER;
        byte_val = DUMMY;
      end
      SLOT_FIN_DONE: act = ACT_DONE;
      default:       act = ACT_REJECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r.mask  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        cur_r <= head_job;
      end else if (emit) begin
        cur_r.mask <= rest;
      end
      if (out_load) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_tuser <= act;
      out_tdata <= byte_val;
      out_tlast <= is_last;
    end
  end

  assign out_tvalid = out_valid_r;

  // The front end never queues a job that produces no results.
  `ASSERT_IMPLY(a_job_nonempty, !q_status.empty, head_job.mask != '0, "empty job in queue")
  // A new job is only taken once the current one is fully emitted.
  `ASSERT_IMPLY(a_pop_clean, pop && have_job, emit && is_last, "job dropped before completion")
  `ASSERT_NEXT(a_out_hold, out_valid_r && !out_tready, out_valid_r && $stable(out_tuser) && $stable(out_tdata) && $stable(out_tlast), "stalled result changed")

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import sncs_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 170;
  localparam int STALL_PCT = 14;
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_POLL_PRE  = 4'd1,
    PH_PROG_DATA = 4'd2,
    PH_POLL_POST = 4'd3,
    PH_READ_DATA = 4'd4
  } seq_phase_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] value;
    logic       last;
  } flash_step_t;

  // Tracks the sequencer state and holds the SPI actions still owed by the block.
  class flash_action_model;
    seq_phase_t  phase;
    logic [1:0]  oper;
    logic [23:0] saved_addr;
    logic [15:0] bytes_left;
    flash_step_t burst[$];
    flash_step_t expected_actions[$];
    int          errors;

    function new();
      phase = PH_IDLE;
      oper = OPER_READ;
      saved_addr = '0;
      bytes_left = '0;
      errors = 0;
    endfunction

    function void emit(logic [2:0] action, logic [7:0] value);
      flash_step_t s;
      s.action = action;
      s.value = value;
      s.last = 1'b0;
      burst.push_back(s);
    endfunction

    function void send_addr(logic [23:0] a);
      emit(ACT_SEND, a[23:16]);
      emit(ACT_SEND, a[15:8]);
      emit(ACT_SEND, a[7:0]);
    endfunction

    function void start_poll();
      emit(ACT_SEL_LOW, 8'h00);
      emit(ACT_SEND, OPC_RDSR);
      emit(ACT_XFER, DUMMY);
    endfunction

    // Close the command frame and begin polling busy for the last time.
    function void finish_command();
      emit(ACT_SEL_HIGH, 8'h00);
      start_poll();
      phase = PH_POLL_POST;
    endfunction

    function void note_command(logic [2:0] cmd, logic [23:0] addr, logic [15:0] count,
                               logic [7:0] data);
      logic fits;
      flash_step_t s;
      fits = 1'b0;
      burst.delete();
      case (phase)
        PH_POLL_PRE: begin
          if (cmd == CMD_RXBYTE) begin
            fits = 1'b1;
            if ((data & BUSY_MASK) != 0) begin
              emit(ACT_XFER, DUMMY);
            end else begin
              emit(ACT_SEL_HIGH, 8'h00);
              emit(ACT_SEL_LOW, 8'h00);
              if (oper == OPER_PROG) begin
                emit(ACT_SEND, OPC_PP);
                send_addr(saved_addr);
                if (bytes_left != 0) phase = PH_PROG_DATA;
                else finish_command();
              end else if (oper == OPER_SERASE) begin
                emit(ACT_SEND, OPC_SE);
                send_addr(saved_addr);
                finish_command();
              end else begin
                emit(ACT_SEND, OPC_CE);
                finish_command();
              end
            end
          end
        end
        PH_PROG_DATA: begin
          if (cmd == CMD_DATA) begin
            fits = 1'b1;
            emit(ACT_SEND, data);
            bytes_left = bytes_left - 16'd1;
            if (bytes_left == 0) finish_command();
          end
        end
        PH_POLL_POST: begin
          if (cmd == CMD_RXBYTE) begin
            fits = 1'b1;
            if ((data & BUSY_MASK) != 0) begin
              emit(ACT_XFER, DUMMY);
            end else begin
              emit(ACT_SEL_HIGH, 8'h00);
              emit(ACT_DONE, 8'h00);
              phase = PH_IDLE;
            end
          end
        end
        PH_READ_DATA: begin
          if (cmd == CMD_RXBYTE) begin
            fits = 1'b1;
            emit(ACT_READ, data);
            bytes_left = bytes_left - 16'd1;
            if (bytes_left != 0) begin
              emit(ACT_XFER, DUMMY);
            end else begin
              emit(ACT_SEL_HIGH, 8'h00);
              emit(ACT_DONE, 8'h00);
              phase = PH_IDLE;
            end
          end
        end
        default: begin
          if (cmd == CMD_READ) begin
            fits = 1'b1;
            oper = OPER_READ;
            saved_addr = addr;
            bytes_left = count;
            emit(ACT_SEL_LOW, 8'h00);
            emit(ACT_SEND, OPC_READ);
            send_addr(addr);
            if (count != 0) begin
              emit(ACT_XFER, DUMMY);
              phase = PH_READ_DATA;
            end else begin
              emit(ACT_SEL_HIGH, 8'h00);
              emit(ACT_DONE, 8'h00);
              phase = PH_IDLE;
            end
          end else if (cmd <= CMD_CERASE) begin
            fits = 1'b1;
            oper = cmd[1:0];
            saved_addr = addr;
            bytes_left = (cmd == CMD_PROG) ? count : 16'd0;
            emit(ACT_SEL_LOW, 8'h00);
            emit(ACT_SEND, OPC_WREN);
            emit(ACT_SEL_HIGH, 8'h00);
            start_poll();
            phase = PH_POLL_PRE;
          end
        end
      endcase
      if (!fits) emit(ACT_REJECT, 8'h00);
      for (int i = 0; i < burst.size(); i++) begin
        s = burst[i];
        s.last = (i == burst.size() - 1);
        expected_actions.push_back(s);
      end
    endfunction

    function void check_action(logic [2:0] action, logic [7:0] value, logic last);
      flash_step_t exp_s;
      if (expected_actions.size() == 0) begin
        $display("%0t: unexpected transaction, action %0d byte %02h last %0b",
                 $time, action, value, last);
        errors++;
        return;
      end
      exp_s = expected_actions.pop_front();
      if (action !== exp_s.action) begin
        $display("%0t: action mismatch, expected %0d actual %0d", $time, exp_s.action, action);
        errors++;
      end
      if (value !== exp_s.value) begin
        $display("%0t: byte mismatch, expected %02h actual %02h", $time, exp_s.value, value);
        errors++;
      end
      if (last !== exp_s.last) begin
        $display("%0t: last mismatch, expected %0b actual %0b", $time, exp_s.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  flash_action_model sb;
  bit calm = 1'b0;
  int cycle_count = 0;

  spi_nor_flash_command_sequencer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_tready <= calm || ($urandom_range(0, 99) >= STALL_PCT);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_action(out_tuser, out_tdata, out_tlast);
  end

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_item(input logic [2:0] cmd, input logic [23:0] addr,
                           input logic [15:0] count, input logic [7:0] data);
    if (!calm && $urandom_range(0, 99) < STALL_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {data, count, addr};
    do @(posedge clk); while (!in_tready);
    sb.note_command(cmd, addr, count, data);
    @(negedge clk);
  endtask

  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    while (sb.expected_actions.size() != 0) @(negedge clk);
  endtask

  // Mostly items that fit the current phase; noise_pct percent are items that do not.
  task automatic send_next(input int noise_pct);
    logic [2:0]  cmd;
    logic [23:0] addr;
    logic [15:0] count;
    logic [7:0]  data;
    logic [2:0]  fit;
    addr = 24'($urandom);
    count = 16'($urandom);
    data = 8'($urandom);
    fit = (sb.phase == PH_PROG_DATA) ? CMD_DATA : CMD_RXBYTE;
    if ($urandom_range(0, 99) < noise_pct) begin
      if (sb.phase == PH_IDLE) begin
        do cmd = 3'($urandom_range(0, 7)); while (cmd <= CMD_CERASE);
      end else begin
        do cmd = 3'($urandom_range(0, 7)); while (cmd == fit);
      end
    end else if (sb.phase == PH_IDLE) begin
      cmd = 3'($urandom_range(CMD_READ, CMD_CERASE));
      count = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(7, 24))
                                          : 16'($urandom_range(0, 6));
    end else begin
      cmd = fit;
      if (sb.phase == PH_POLL_PRE || sb.phase == PH_POLL_POST)
        data[0] = ($urandom_range(0, 99) < 35);
    end
    send_item(cmd, addr, count, data);
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Items that never fit while idle, including the spare codes.
    send_item(CMD_DATA, 24'hFFFFFF, 16'hFFFF, 8'hFF);
    send_item(CMD_RXBYTE, 24'h000000, 16'h0000, 8'h00);
    send_item(CMD_SPARE6, 24'h5A5A5A, 16'h8001, 8'h80);
    send_item(CMD_SPARE7, 24'hFFFFFF, 16'hFFFF, 8'hFF);
    // A read of nothing still sends the address.
    send_item(CMD_READ, 24'hFFFFFF, 16'h0000, 8'hFF);
    send_item(CMD_READ, 24'h000000, 16'h0002, 8'h00);
    send_item(CMD_DATA, 24'h000000, 16'h0000, 8'h11);
    send_item(CMD_READ, 24'hFFFFFF, 16'hFFFF, 8'hFF);
    send_item(CMD_RXBYTE, 24'hFFFFFF, 16'hFFFF, 8'h00);
    send_item(CMD_RXBYTE, 24'h000000, 16'h0000, 8'hFF);
    // Page program with busy seen once before and once after the command.
    send_item(CMD_PROG, 24'hA5A5A5, 16'h0002, 8'h00);
    send_item(CMD_RXBYTE, 24'h000000, 16'h0000, 8'h01);
    send_item(CMD_DATA, 24'h000000, 16'h0000, 8'h22);
    send_item(CMD_RXBYTE, 24'h000000, 16'h0000, 8'hFE);
    send_item(CMD_RXBYTE, 24'h000000, 16'h0000, 8'h00);
    send_item(CMD_DATA, 24'h000000, 16'h0000, 8'hFF);
    send_item(CMD_DATA, 24'h000000, 16'h0000, 8'h00);
    send_item(CMD_RXBYTE, 24'h000000, 16'h0000, 8'h03);
    send_item(CMD_RXBYTE, 24'h000000, 16'h0000, 8'h00);
    send_item(CMD_SERASE, 24'h123456, 16'hFFFF, 8'hFF);
    send_item(CMD_RXBYTE, 24'h000000, 16'h0000, 8'h00);
    send_item(CMD_RXBYTE, 24'h000000, 16'h0000, 8'h00);
    send_item(CMD_CERASE, 24'hFFFFFF, 16'h0000, 8'h00);
    send_item(CMD_RXBYTE, 24'h000000, 16'h0000, 8'h00);
    send_item(CMD_RXBYTE, 24'h000000, 16'h0000, 8'h00);
    // Program of zero bytes goes straight to the final poll.
    send_item(CMD_PROG, 24'h000000, 16'h0000, 8'h00);
    send_item(CMD_RXBYTE, 24'h000000, 16'h0000, 8'h00);
    send_item(CMD_RXBYTE, 24'h000000, 16'h0000, 8'h00);
    hold_until_drained();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm = (i >= 60 && i < 110);
      if (i == 140) hold_until_drained();
      send_next(12);
    end
    calm = 1'b0;

    // Finish whatever is open.
    while (sb.phase != PH_IDLE) send_next(0);
    in_tvalid <= 1'b0;

    while (sb.expected_actions.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.expected_actions.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
